// ----- design/cppm_pkg.sv -----
// ----------------------------------------------------------------------------
// cppm_pkg
// Types and codes shared by the combined PPM frame decoder: the request and
// response payloads, the function codes and the register indexes.
// ----------------------------------------------------------------------------
package cppm_pkg;

   // Function codes carried by a request item.
   localparam logic FUNC_EDGE = 1'b0;   // captured edge timestamp
   localparam logic FUNC_READ = 1'b1;   // read one latched channel

   // Register indexes on the configuration port.
   localparam int  CSR_INDEX_W       = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SYNC_GAP      = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHANNEL_COUNT = 1'b1;

   localparam int  CSR_DATA_W   = 32;
   localparam int  TIME_W       = 32;
   localparam int  COUNT_CFG_W  = 5;
   localparam int  CHAN_IDX_W   = 8;

   localparam logic [TIME_W-1:0]      SYNC_GAP_RESET      = 32'd3000;
   localparam logic [COUNT_CFG_W-1:0] CHANNEL_COUNT_RESET = 5'd8;

   typedef struct packed {
      logic                  func;
      logic [TIME_W-1:0]     edge_time;
      logic [CHAN_IDX_W-1:0] channel_index;
   } req_type;

   typedef struct packed {
      logic [TIME_W-1:0] channel_value;
      logic              frame_ready;
      logic              frame_done;
   } rsp_type;

endpackage

// ----- design/cppm_frame_decoder.sv -----
// ----------------------------------------------------------------------------
// cppm_frame_decoder
// Decodes a combined PPM stream from captured edge timestamps and serves
// reads of the most recently completed frame.
// ----------------------------------------------------------------------------
//
//   Port group  Direction  Handshake            Payload
//   req_        in         req_valid/req_stall  cppm_pkg::req_type
//   rsp_        out        rsp_valid/rsp_stall  cppm_pkg::rsp_type
//   csr_        in         csr_valid/csr_ready  csr_index, csr_data
//
// Every item is processed in the cycle it is accepted: the interval math,
// the sync test, the width store, the frame latch and the channel read all
// sit between the state registers and the response register. One item per
// cycle is sustained while req_stall is low; each result is registered.
// Reset is synchronous and active high. It clears the control state and the
// frame image and loads sync_gap = 3000 and channel_count = 8. A response
// register backed by a one-item skid buffer keeps accepting while a result
// waits; req_stall rises only once both are full and the consumer stalls.
// csr_ready is always high; registers must be written only while idle, which the block does not enforce.
//
module cppm_frame_decoder #(
   parameter int MAX_CHANNELS = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,

   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  cppm_pkg::req_type                      req_data,

   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output cppm_pkg::rsp_type                      rsp_data,

   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [cppm_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [cppm_pkg::CSR_DATA_W-1:0]        csr_data
);
   import cppm_pkg::*;

   // Width of a channel counter (holds 0..MAX_CHANNELS) and of an array index.
   localparam int CNT_W = $clog2(MAX_CHANNELS + 1);
   localparam int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   // Common width for comparing the 5-bit count setting against the depth.
   localparam int CMP_W = 9;

   // Configuration registers.
   logic [TIME_W-1:0]      sync_gap_ff;
   logic [COUNT_CFG_W-1:0] channel_count_ff;

   // Decoder state.
   logic [TIME_W-1:0] prev_time_ff,  prev_time_in;
   logic [CNT_W-1:0]  pulse_count_ff, pulse_count_in;
   logic              in_frame_ff,   in_frame_in;
   logic              new_frame_ff,  new_frame_in;
   logic [TIME_W-1:0] working_ff [MAX_CHANNELS];
   logic [TIME_W-1:0] working_in [MAX_CHANNELS];
   logic [TIME_W-1:0] image_ff   [MAX_CHANNELS];
   logic [TIME_W-1:0] image_in   [MAX_CHANNELS];

   // Response register and skid buffer.
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;
   logic    skid_valid_ff;
   rsp_type skid_data_ff;

   logic              req_accept;
   logic              rsp_take;
   logic [CNT_W-1:0]  eff_count;
   logic [TIME_W-1:0] interval;
   logic [IDX_W-1:0]  rd_idx;
   rsp_type           result;

   assign req_accept = req_valid && !req_stall;
   assign rsp_take   = rsp_valid_ff && !rsp_stall;
   assign req_stall  = skid_valid_ff;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign csr_ready  = 1'b1;

   // Effective channel count: a setting of zero acts as one, and a setting
   // above the array depth acts as the depth.
   always_comb begin
      priority if (channel_count_ff == '0) begin
         eff_count = CNT_W'(1);
      end else if (CMP_W'(channel_count_ff) > CMP_W'(MAX_CHANNELS)) begin
         eff_count = CNT_W'(MAX_CHANNELS);
      end else begin
         eff_count = CNT_W'(channel_count_ff);
      end
   end

   // The interval wraps modulo 2^32 along with the capture timer.
   assign interval = req_data.edge_time - prev_time_ff;

   // A read index at or past the last channel is clamped to the last one.
   always_comb begin
      if (CMP_W'(req_data.channel_index) >= CMP_W'(eff_count)) begin
         rd_idx = IDX_W'(eff_count - CNT_W'(1));
      end else begin
         rd_idx = IDX_W'(req_data.channel_index);
      end
   end

   // Single-pass item processing.
   always_comb begin
      prev_time_in   = prev_time_ff;
      pulse_count_in = pulse_count_ff;
      in_frame_in    = in_frame_ff;
      new_frame_in   = new_frame_ff;
      working_in     = working_ff;
      image_in       = image_ff;

      result.channel_value = '0;
      result.frame_ready   = new_frame_ff;
      result.frame_done    = 1'b0;

      if (req_accept) begin
         if (req_data.func == FUNC_READ) begin
            result.channel_value = image_ff[rd_idx];
            new_frame_in         = 1'b0;
         end else begin
            prev_time_in = req_data.edge_time;
            if (interval > sync_gap_ff) begin
               // A long gap opens a frame, also in the middle of one.
               pulse_count_in = '0;
               in_frame_in    = 1'b1;
            end else if (in_frame_ff && (pulse_count_ff < eff_count)) begin
               working_in[pulse_count_ff[IDX_W-1:0]] = interval;
               pulse_count_in = pulse_count_ff + CNT_W'(1);
            end

            // The frame closes once the count is reached. This also catches a
            // count lowered below the number of widths already collected.
            if (in_frame_in && (pulse_count_in >= eff_count)) begin
               for (int i = 0; i < MAX_CHANNELS; i++) begin
                  if (CNT_W'(i) < eff_count) begin
                     image_in[i] = working_in[i];
                  end
               end
               in_frame_in       = 1'b0;
               pulse_count_in    = '0;
               new_frame_in      = 1'b1;
               result.frame_done = 1'b1;
            end
         end
      end
   end

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         sync_gap_ff      <= SYNC_GAP_RESET;
         channel_count_ff <= CHANNEL_COUNT_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SYNC_GAP:      sync_gap_ff      <= csr_data;
            CSR_CHANNEL_COUNT: channel_count_ff <= csr_data[COUNT_CFG_W-1:0];
            default: ;
         endcase
      end
   end

   // Decoder state and frame image.
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_time_ff   <= '0;
         pulse_count_ff <= '0;
         in_frame_ff    <= 1'b0;
         new_frame_ff   <= 1'b0;
         for (int i = 0; i < MAX_CHANNELS; i++) begin
            image_ff[i] <= '0;
         end
      end else begin
         prev_time_ff   <= prev_time_in;
         pulse_count_ff <= pulse_count_in;
         in_frame_ff    <= in_frame_in;
         new_frame_ff   <= new_frame_in;
         image_ff       <= image_in;
      end
   end

   // The working widths are only read after they have been written.
   always_ff @(posedge clock) begin
      working_ff <= working_in;
   end

   // Response register with skid buffer.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (skid_valid_ff) begin
            if (rsp_take) begin
               skid_valid_ff <= 1'b0;
            end
         end else if (req_accept) begin
            if (rsp_valid_ff && !rsp_take) begin
               skid_valid_ff <= 1'b1;
            end else begin
               rsp_valid_ff <= 1'b1;
            end
         end else if (rsp_take) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (rsp_take) begin
            rsp_data_ff <= skid_data_ff;
         end
      end else if (req_accept) begin
         if (rsp_valid_ff && !rsp_take) begin
            skid_data_ff <= result;
         end else begin
            rsp_data_ff <= result;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------

   // The skid buffer only fills behind a waiting response.
   a_skid_behind_rsp: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid buffer holds an item while the response register is empty");

   // Outside a frame no widths are being counted.
   a_idle_count_zero: assert property (@(posedge clock) disable iff (reset)
      !in_frame_ff |-> (pulse_count_ff == '0))
      else $error("pulse count nonzero while waiting for sync");

   // A frame that completes raises the new-frame flag for the next item.
   a_done_sets_flag: assert property (@(posedge clock) disable iff (reset)
      (req_accept && result.frame_done) |=> new_frame_ff)
      else $error("completed frame did not set the new-frame flag");

   // A read clears the new-frame flag.
   a_read_clears_flag: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_data.func == FUNC_READ)) |=> !new_frame_ff)
      else $error("channel read left the new-frame flag set");

endmodule
